// ===== hdl/upd_pkg.sv =====
// Shared types, constants and helper functions for the URL percent decoder.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CASE_MASK  = 8'hDF;
    localparam logic [7:0] NIB_OFFSET = 8'd10;

    // Result queue geometry
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    // Highest fill at which a new input transaction may still be taken:
    // the item in flight and the new one push at most two entries each.
    localparam logic [QCW-1:0] Q_ROOM_MAX = QCW'(QDEPTH - 4);

    // Results produced by one decoded input byte (0, 1 or 2)
    typedef struct packed {
        logic [1:0] num;
        logic [7:0] data0;
        logic       last0;
        logic [7:0] data1;
        logic       last1;
    } t_dec_res;

    function automatic logic [7:0] f_nibble(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= CH_UPPER_A && !c[7]) begin
                v = (c & CASE_MASK) - CH_UPPER_A + NIB_OFFSET;
            end else begin
                v = c - CH_ZERO;
            end
            return v;
        end
    endfunction

    function automatic logic [7:0] f_plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

// ===== hdl/url_percent_decoder_top.sv =====
// Top level of the streaming URL percent decoder.
`timescale 1ns / 1ps

// URL percent decoder, one encoded byte per transaction.
// Input channel s_axis: tdata carries the raw byte, tlast marks the final
// byte of an encoded string. Output channel m_axis: tdata carries a decoded
// byte, tlast marks the final decoded byte of the string.
// '+' turns into a space; '%' plus two following bytes of the same string
// turns into one byte built from their nibbles (no hex check); a '%' with
// fewer than two bytes after it goes out as a literal '%'.
// Pipeline: input register -> decode with escape state -> 8-entry result
// queue that drives m_axis directly from registers.
// A result passes the input register and then the result queue to m_axis.
// Throughput: one input transaction per cycle while s_axis_tready is high.
// An input byte yields zero, one or two results; the output drains one
// per cycle while m_axis_tready is high, so a short escape at the end of a
// string costs one extra output transaction.
// s_axis_tready comes only from the registered queue fill: it drops when the
// queue holds more than four results, so a stalled receiver backs up the
// input without losing anything.
// Reset (i_rst_n low, synchronous): escape state cleared, queue emptied,
// pending input dropped.
module url_percent_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // out_last
);
    import upd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       w_room;
    t_dec_res   w_res;

    assign s_axis_tready = w_room;

    // Input register: captures one transaction per cycle when tready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_axis_tvalid && s_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_data <= s_axis_tdata;
        r_in_last <= s_axis_tlast;
    end

    upd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_data  (r_in_data),
        .i_last  (r_in_last),
        .o_res   (w_res)
    );

    upd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .i_pop   (m_axis_tready),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== hdl/upd_decode.sv =====
// Escape state machine and byte decode for the URL percent decoder.
`timescale 1ns / 1ps

module upd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    output upd_pkg::t_dec_res o_res
);
    import upd_pkg::*;

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_HIGH = 3'b100
    } t_esc_phase;

    t_esc_phase r_phase, n_phase;
    logic [7:0] r_high, n_high;
    logic [7:0] w_nib_hi, w_nib_lo;

    assign w_nib_hi = f_nibble(r_high);
    assign w_nib_lo = f_nibble(i_data);

    always_comb begin
        n_phase     = r_phase;
        n_high      = r_high;
        o_res.num   = 2'd0;
        o_res.data0 = f_plain(i_data);
        o_res.last0 = i_last;
        o_res.data1 = f_plain(i_data);
        o_res.last1 = 1'b1;
        if (i_valid) begin
            unique case (r_phase)
                ESC_PCT: begin
                    if (i_last) begin
                        n_phase     = ESC_IDLE;
                        o_res.num   = 2'd2;
                        o_res.data0 = CH_PERCENT;
                        o_res.last0 = 1'b0;
                    end else begin
                        n_phase = ESC_HIGH;
                        n_high  = i_data;
                    end
                end
                ESC_HIGH: begin
                    n_phase     = ESC_IDLE;
                    o_res.num   = 2'd1;
                    o_res.data0 = {w_nib_hi[3:0], 4'h0} + w_nib_lo;
                end
                default: begin
                    n_phase = ESC_IDLE;
                    if (i_data == CH_PERCENT && !i_last) begin
                        n_phase = ESC_PCT;
                    end else begin
                        o_res.num = 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
            r_high  <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_high  <= n_high;
        end
    end

`ifndef NO_ASSERTIONS
    a_two_only_on_short_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.num == 2'd2 |-> r_phase == ESC_PCT && i_last && i_valid)
        else $error("two results outside a short escape");
    a_last_clears_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |=> r_phase == ESC_IDLE)
        else $error("escape pending after last byte");
`endif

endmodule

// ===== hdl/upd_out_queue.sv =====
// Result queue: up to two results in, one out on each pop, per cycle.
`timescale 1ns / 1ps

module upd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  upd_pkg::t_dec_res i_res,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output logic [7:0]        o_data,
    output logic              o_last
);
    import upd_pkg::*;

    logic [8:0]     r_mem [QDEPTH];
    logic [QAW-1:0] r_head, n_head;
    logic [QAW-1:0] r_tail, n_tail;
    logic [QCW-1:0] r_count, n_count;
    logic [QAW-1:0] w_tail1;
    logic           w_pop;

    assign w_tail1 = r_tail + QAW'(1);
    assign w_pop   = i_pop && (r_count != '0);

    always_comb begin
        n_head  = w_pop ? r_head + QAW'(1) : r_head;
        n_tail  = r_tail + QAW'(i_res.num);
        n_count = r_count + QCW'(i_res.num) - QCW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.num != 2'd0) begin
            r_mem[r_tail] <= {i_res.last0, i_res.data0};
        end
        if (i_res.num == 2'd2) begin
            r_mem[w_tail1] <= {i_res.last1, i_res.data1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_room  = (r_count <= Q_ROOM_MAX);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head][7:0];
    assign o_last  = r_mem[r_head][8];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + QCW'(i_res.num)) <= QCW'(QDEPTH))
        else $error("result queue overflow");
    a_ptr_count_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QAW'(r_tail - r_head) == r_count[QAW-1:0])
        else $error("queue pointers disagree with fill count");
`endif

endmodule
